FILE: rtl/u8svd_pkg.sv
package u8svd_pkg;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEAD = 2'd1,
    ERR_CONT = 2'd2
  } err_kind_t;

  typedef enum logic [1:0] {
    REG_FIXED_ON   = 2'd0,
    REG_FIXED_SIZE = 2'd1,
    REG_SKIP_CHECK = 2'd2
  } reg_index_t;

  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  // width of a lead byte, 0 when it is not a lead byte
  function automatic logic [2:0] classify_lead(input logic [7:0] b);
    logic [2:0] w;
    priority if ((b & MASK_ASCII) == 8'h00)      w = 3'd1;
    else if ((b & MASK_LEAD2) == PAT_LEAD2)      w = 3'd2;
    else if ((b & MASK_LEAD3) == PAT_LEAD3)      w = 3'd3;
    else if ((b & MASK_LEAD4) == PAT_LEAD4)      w = 3'd4;
    else                                         w = 3'd0;
    return w;
  endfunction

  // payload bits a lead byte keeps for a given symbol width
  function automatic logic [7:0] lead_keep(input logic [2:0] w);
    logic [7:0] m;
    unique case (w)
      3'd1:    m = 8'hFF;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/utf8_stream_validate_decode.sv
// UTF-8 byte stream validator and decoder.
// An accepted byte's result is registered and is in the output register in the next cycle.
// Throughput: one byte per cycle unless a held result is not taken; the decode
// state is read and written in the same cycle, so its update loop sets the rate.
// Reset (synchronous, rst_n low): string state cleared, configuration back to
// fixed width off, group size 1, checks on; output register empty.
module utf8_stream_validate_decode #(
  parameter int MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_symbol_done,
  output logic [20:0] out_codepoint,
  output logic [15:0] out_sym_index,
  output logic [16:0] out_symbol_count,
  output logic [1:0]  out_error_kind,
  output logic [15:0] out_error_byte_index,
  output logic [2:0]  out_expected_width
);

  localparam longint BYTE_CAP_L  = (longint'(MAX_BYTES) - 1 > 65535) ? 65535
                                   : longint'(MAX_BYTES) - 1;
  localparam longint COUNT_CAP_L = (longint'(MAX_BYTES) > 65536) ? 65536
                                   : longint'(MAX_BYTES);
  localparam logic [15:0] BYTE_CAP  = 16'(BYTE_CAP_L);
  localparam logic [16:0] COUNT_CAP = 17'(COUNT_CAP_L);

  // configuration
  logic       fixed_on_r;
  logic [2:0] fixed_size_r;
  logic       skip_r;

  // string state
  logic [1:0]  pend_r,     pend_nxt;
  logic [2:0]  width_r,    width_nxt;
  logic [20:0] partial_r,  partial_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;
  logic [15:0] lead_pos_r, lead_pos_nxt;
  logic [16:0] seen_r,     seen_nxt;
  logic        halted_r,   halted_nxt;

  // result register
  logic        out_valid_r;
  logic        done_r;
  logic [20:0] code_r;
  logic [15:0] idx_r;
  logic [16:0] count_r;
  u8svd_pkg::err_kind_t err_r;
  logic [15:0] err_pos_r;
  logic [2:0]  exp_w_r;

  logic        accept;
  logic        done_nxt;
  logic [20:0] code_nxt;
  logic [15:0] idx_nxt;
  u8svd_pkg::err_kind_t err_nxt;
  logic [15:0] err_pos_nxt;
  logic [2:0]  exp_w_nxt;

  // state as seen by this byte (a first flag clears the string beforehand)
  logic [1:0]  pend_c;
  logic [2:0]  width_c;
  logic [20:0] partial_c;
  logic [15:0] byte_pos_c;
  logic [15:0] lead_pos_c;
  logic [16:0] seen_c;
  logic        halted_c;

  logic [2:0]  cls;
  logic [2:0]  grp_w;
  logic [2:0]  w;
  logic        lead_ok;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign pend_c     = in_first ? 2'd0  : pend_r;
  assign width_c    = in_first ? 3'd0  : width_r;
  assign partial_c  = in_first ? 21'd0 : partial_r;
  assign byte_pos_c = in_first ? 16'd0 : byte_pos_r;
  assign lead_pos_c = in_first ? 16'd0 : lead_pos_r;
  assign seen_c     = in_first ? 17'd0 : seen_r;
  assign halted_c   = in_first ? 1'b0  : halted_r;

  assign cls = u8svd_pkg::classify_lead(in_data_byte);

  // group size 0 acts as 1, 5 to 7 act as 4
  always_comb begin
    if (fixed_size_r == 3'd0) begin
      grp_w = 3'd1;
    end else if (fixed_size_r > 3'd4) begin
      grp_w = 3'd4;
    end else begin
      grp_w = fixed_size_r;
    end
  end

  assign w       = fixed_on_r ? grp_w : cls;
  assign lead_ok = (fixed_on_r && skip_r) || (cls != 3'd0);

  always_comb begin
    pend_nxt     = pend_c;
    width_nxt    = width_c;
    partial_nxt  = partial_c;
    byte_pos_nxt = byte_pos_c;
    lead_pos_nxt = lead_pos_c;
    seen_nxt     = seen_c;
    halted_nxt   = halted_c;
    done_nxt     = 1'b0;
    err_nxt      = u8svd_pkg::ERR_NONE;
    err_pos_nxt  = 16'd0;
    exp_w_nxt    = 3'd0;
    idx_nxt      = seen_c[16] ? 16'hFFFF : seen_c[15:0];

    if (!halted_c) begin
      if (pend_c != 2'd0) begin
        if (!skip_r && ((in_data_byte & u8svd_pkg::MASK_CONT) != u8svd_pkg::PAT_CONT)) begin
          err_nxt     = u8svd_pkg::ERR_CONT;
          err_pos_nxt = lead_pos_c;
          exp_w_nxt   = width_c;
          halted_nxt  = 1'b1;
        end else begin
          partial_nxt = {partial_c[14:0], in_data_byte[5:0]};
          pend_nxt    = pend_c - 2'd1;
          done_nxt    = (pend_c == 2'd1);
        end
      end else if (!lead_ok) begin
        err_nxt     = u8svd_pkg::ERR_LEAD;
        err_pos_nxt = byte_pos_c;
        halted_nxt  = 1'b1;
      end else begin
        lead_pos_nxt = byte_pos_c;
        width_nxt    = w;
        partial_nxt  = {13'd0, in_data_byte & u8svd_pkg::lead_keep(w)};
        pend_nxt     = 2'(w - 3'd1);
        done_nxt     = (w == 3'd1);
      end

      if (done_nxt && (seen_c < COUNT_CAP)) begin
        seen_nxt = seen_c + 17'd1;
      end
      if (!halted_nxt && (byte_pos_c < BYTE_CAP)) begin
        byte_pos_nxt = byte_pos_c + 16'd1;
      end
    end

    code_nxt = done_nxt ? partial_nxt : 21'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_on_r   <= 1'b0;
      fixed_size_r <= 3'd1;
      skip_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u8svd_pkg::REG_FIXED_ON:   fixed_on_r   <= cfg_wdata[0];
        u8svd_pkg::REG_FIXED_SIZE: fixed_size_r <= cfg_wdata;
        u8svd_pkg::REG_SKIP_CHECK: skip_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 2'd0;
      width_r    <= 3'd0;
      partial_r  <= 21'd0;
      byte_pos_r <= 16'd0;
      lead_pos_r <= 16'd0;
      seen_r     <= 17'd0;
      halted_r   <= 1'b0;
    end else if (accept) begin
      pend_r     <= pend_nxt;
      width_r    <= width_nxt;
      partial_r  <= partial_nxt;
      byte_pos_r <= byte_pos_nxt;
      lead_pos_r <= lead_pos_nxt;
      seen_r     <= seen_nxt;
      halted_r   <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_r    <= done_nxt;
      code_r    <= code_nxt;
      idx_r     <= idx_nxt;
      count_r   <= seen_nxt;
      err_r     <= err_nxt;
      err_pos_r <= err_pos_nxt;
      exp_w_r   <= exp_w_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_symbol_done      = done_r;
  assign out_codepoint        = code_r;
  assign out_sym_index        = idx_r;
  assign out_symbol_count     = count_r;
  assign out_error_kind       = err_r;
  assign out_error_byte_index = err_pos_r;
  assign out_expected_width   = exp_w_r;

  // an error request never completes a symbol
  a_err_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (err_r != u8svd_pkg::ERR_NONE) |-> !done_r)
    else $error("error result also flags a completed symbol");

  // once halted, bytes of the same string give empty results
  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && halted_r && !in_first |=> (err_r == u8svd_pkg::ERR_NONE) && !done_r)
    else $error("result produced while halted on error");

  // a bad lead byte has no expected width
  a_lead_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (err_r == u8svd_pkg::ERR_LEAD) |-> (exp_w_r == 3'd0))
    else $error("bad lead byte reports a width");

  // symbol count stays within its saturation limit
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= COUNT_CAP)
    else $error("symbol count beyond its limit");

endmodule

FILE: tb/sv/utf8_svd_check.sv
`timescale 1ns / 1ps

module utf8_svd_check #(
  parameter int MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_symbol_done,
  input  logic [20:0] out_codepoint,
  input  logic [15:0] out_sym_index,
  input  logic [16:0] out_symbol_count,
  input  logic [1:0]  out_error_kind,
  input  logic [15:0] out_error_byte_index,
  input  logic [2:0]  out_expected_width,

  output int          errors,
  output int          waiting
);

  localparam int BYTE_CAP = (MAX_BYTES - 1 > 65535) ? 65535 : MAX_BYTES - 1;
  localparam int SYM_CAP  = (MAX_BYTES > 65536) ? 65536 : MAX_BYTES;

  typedef struct packed {
    logic        done;
    logic [20:0] code;
    logic [15:0] idx;
    logic [16:0] count;
    u8svd_pkg::err_kind_t err;
    logic [15:0] err_pos;
    logic [2:0]  exp_w;
  } decode_rec_t;

  // configuration as last written
  logic        fixed_on;
  logic [2:0]  group_cfg;
  logic        skip_chk;

  // string state
  logic [1:0]  pend;
  logic [2:0]  sym_w;
  logic [20:0] acc;
  logic [15:0] byte_pos;
  logic [15:0] lead_pos;
  logic [16:0] n_sym;
  logic        halted;

  decode_rec_t due_q[$];
  decode_rec_t head_r;

  function automatic void clear_string();
    pend     = '0;
    sym_w    = '0;
    acc      = '0;
    byte_pos = '0;
    lead_pos = '0;
    n_sym    = '0;
    halted   = 1'b0;
  endfunction

  function automatic logic [2:0] lead_width(input logic [7:0] b);
    logic [2:0] w;
    casez (b)
      8'b0???????: w = 3'd1;
      8'b110?????: w = 3'd2;
      8'b1110????: w = 3'd3;
      8'b11110???: w = 3'd4;
      default:     w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic decode_rec_t decode_byte(input logic [7:0] b, input logic first);
    decode_rec_t r;
    logic [2:0]  cls;
    logic [2:0]  w;
    logic [7:0]  keep;
    logic        ok;
    r.done    = 1'b0;
    r.code    = '0;
    r.err     = u8svd_pkg::ERR_NONE;
    r.err_pos = '0;
    r.exp_w   = '0;
    if (first) clear_string();
    r.idx = (n_sym > 17'hFFFF) ? 16'hFFFF : n_sym[15:0];
    if (!halted) begin
      if (pend != 2'd0) begin
        if (!skip_chk && b[7:6] != 2'b10) begin
          r.err     = u8svd_pkg::ERR_CONT;
          r.err_pos = lead_pos;
          r.exp_w   = sym_w;
          halted    = 1'b1;
        end else begin
          acc  = {acc[14:0], b[5:0]};
          pend = pend - 2'd1;
          if (pend == 2'd0) r.done = 1'b1;
        end
      end else begin
        cls = lead_width(b);
        if (fixed_on) begin
          // group size clamps to 1..4
          if (group_cfg == 3'd0)     w = 3'd1;
          else if (group_cfg > 3'd4) w = 3'd4;
          else                       w = group_cfg;
          ok = skip_chk || (cls != 3'd0);
        end else begin
          w  = cls;
          ok = (cls != 3'd0);
        end
        if (!ok) begin
          r.err     = u8svd_pkg::ERR_LEAD;
          r.err_pos = byte_pos;
          r.exp_w   = 3'd0;
          halted    = 1'b1;
        end else begin
          case (w)
            3'd1:    keep = 8'hFF;
            3'd2:    keep = 8'h1F;
            3'd3:    keep = 8'h0F;
            default: keep = 8'h07;
          endcase
          lead_pos = byte_pos;
          sym_w    = w;
          acc      = {13'd0, b & keep};
          pend     = w[1:0] - 2'd1;
          if (w == 3'd1) r.done = 1'b1;
        end
      end
      if (r.done) begin
        r.code = acc;
        if (n_sym < SYM_CAP) n_sym = n_sym + 17'd1;
      end
      if (!halted && byte_pos < BYTE_CAP) byte_pos = byte_pos + 16'd1;
    end
    r.count = n_sym;
    return r;
  endfunction

  function automatic int field_bad(input string name, input longint unsigned want,
                                   input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fixed_on  = 1'b0;
      group_cfg = 3'd1;
      skip_chk  = 1'b0;
      clear_string();
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          u8svd_pkg::REG_FIXED_ON:   fixed_on  = cfg_wdata[0];
          u8svd_pkg::REG_FIXED_SIZE: group_cfg = cfg_wdata;
          u8svd_pkg::REG_SKIP_CHECK: skip_chk  = cfg_wdata[0];
          default: ;
        endcase
      end
      // retire before taking the new request: a result is never same-cycle
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("result accepted with nothing outstanding");
          errors++;
        end else begin
          head_r = due_q.pop_front();
          errors += field_bad("symbol_done", head_r.done, out_symbol_done);
          errors += field_bad("codepoint", head_r.code, out_codepoint);
          errors += field_bad("sym_index", head_r.idx, out_sym_index);
          errors += field_bad("symbol_count", head_r.count, out_symbol_count);
          errors += field_bad("error_kind", head_r.err, out_error_kind);
          errors += field_bad("error_byte_index", head_r.err_pos, out_error_byte_index);
          errors += field_bad("expected_width", head_r.exp_w, out_expected_width);
        end
      end
      if (in_valid && in_ready) due_q.insert(due_q.size(), decode_byte(in_data_byte, in_first));
    end
    waiting = due_q.size();
  end

endmodule

FILE: tb/sv/utf8_stream_validate_decode_tb.sv
`timescale 1ns / 1ps

module utf8_stream_validate_decode_tb;

  localparam int MAX_BYTES = 65536;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
  } byte_req_t;

  typedef enum {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_EVERY4
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  u8svd_pkg::reg_index_t cfg_index;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first;
  logic        out_valid;
  logic        out_ready;
  logic        out_symbol_done;
  logic [20:0] out_codepoint;
  logic [15:0] out_sym_index;
  logic [16:0] out_symbol_count;
  logic [1:0]  out_error_kind;
  logic [15:0] out_error_byte_index;
  logic [2:0]  out_expected_width;

  int chk_errors;
  int chk_waiting;

  bit fast_io;
  int hold_ticket;

  byte_req_t stim_q[$];

  utf8_stream_validate_decode #(.MAX_BYTES(MAX_BYTES)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_first             (in_first),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_symbol_done      (out_symbol_done),
    .out_codepoint        (out_codepoint),
    .out_sym_index        (out_sym_index),
    .out_symbol_count     (out_symbol_count),
    .out_error_kind       (out_error_kind),
    .out_error_byte_index (out_error_byte_index),
    .out_expected_width   (out_expected_width)
  );

  utf8_svd_check #(.MAX_BYTES(MAX_BYTES)) u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_first             (in_first),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_symbol_done      (out_symbol_done),
    .out_codepoint        (out_codepoint),
    .out_sym_index        (out_sym_index),
    .out_symbol_count     (out_symbol_count),
    .out_error_kind       (out_error_kind),
    .out_error_byte_index (out_error_byte_index),
    .out_expected_width   (out_expected_width),
    .errors               (chk_errors),
    .waiting              (chk_waiting)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: always ready under fast_io, else changing stall patterns plus a long hold-off on request
  initial begin
    int       served;
    int       left;
    int       k;
    rx_mode_t mode;
    out_ready = 1'b0;
    served = 0;
    left = 0;
    k = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk);
      if (fast_io) begin
        out_ready = 1'b1;
      end else if (hold_ticket != served) begin
        served = hold_ticket;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(8, 64);
        end
        left--;
        k++;
        case (mode)
          RX_OPEN:   out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready = ($urandom_range(0, 9) != 0);
          default:   out_ready = (k % 4 != 0);
        endcase
      end
    end
  end

  task automatic add(input logic [7:0] b, input logic f);
    byte_req_t r;
    r.b = b;
    r.first = f;
    stim_q.insert(stim_q.size(), r);
  endtask

  function automatic logic [7:0] lead_byte(input int w);
    logic [7:0] x;
    x = 8'($urandom);
    case (w)
      1:       x[7] = 1'b0;
      2:       x[7:5] = 3'b110;
      3:       x[7:4] = 4'b1110;
      default: x[7:3] = 5'b11110;
    endcase
    return x;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] x;
    x = 8'($urandom);
    x[7:6] = 2'b10;
    return x;
  endfunction

  function automatic logic [7:0] not_cont_byte();
    logic [7:0] x;
    x = 8'($urandom);
    if (x[7:6] == 2'b10) x[6] = 1'b1;
    return x;
  endfunction

  task automatic set_reg(input u8svd_pkg::reg_index_t idx, input logic [2:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drives stim_q out in bursts; entered and left at a falling edge
  task automatic send_all();
    int burst;
    int gap;
    burst = 0;
    while (stim_q.size() > 0) begin
      if (burst == 0) begin
        burst = fast_io ? 32'h7FFF_FFFF : $urandom_range(1, 16);
        gap = (fast_io || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid = 1'b1;
      in_data_byte = stim_q[0].b;
      in_first = stim_q[0].first;
      void'(stim_q.pop_front());
      burst--;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (chk_waiting != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // mostly well-formed strings, with stray bytes, broken and cut-off symbols
  task automatic build_random(input int n, input logic fx_on, input logic [2:0] fx_size);
    int   made;
    int   nsym;
    int   s;
    int   w;
    int   g;
    int   r;
    int   k;
    logic f;
    made = 0;
    g = (fx_size == 3'd0) ? 1 : (fx_size > 3'd4) ? 4 : fx_size;
    f = ($urandom_range(0, 3) != 0);
    while (made < n) begin
      nsym = $urandom_range(1, 10);
      for (s = 0; s < nsym; s++) begin
        r = $urandom_range(0, 99);
        w = fx_on ? g : $urandom_range(1, 4);
        if (r < 84) begin
          add(lead_byte(fx_on ? $urandom_range(1, 4) : w), f);
          for (k = 1; k < w; k++) add(cont_byte(), 1'b0);
          made += w;
        end else if (r < 91) begin
          add(8'($urandom), f);
          made++;
        end else if (r < 96) begin
          if (w < 2) w = 2;
          add(lead_byte(w), f);
          k = $urandom_range(1, w - 1);
          repeat (k - 1) add(cont_byte(), 1'b0);
          add(not_cont_byte(), 1'b0);
          made += k + 1;
        end else begin
          // symbol left unfinished; the next request opens a new string
          if (w < 2) w = 2;
          add(lead_byte(w), f);
          k = $urandom_range(0, w - 2);
          repeat (k) add(cont_byte(), 1'b0);
          made += k + 1;
          f = 1'b1;
          continue;
        end
        f = 1'b0;
      end
      f = 1'b1;
    end
  endtask

  initial begin
    logic       ph_on   [12];
    logic [2:0] ph_size [12];
    logic       ph_skip [12];
    int         i;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = u8svd_pkg::REG_FIXED_ON;
    cfg_wdata = 3'd0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_first = 1'b0;
    fast_io = 1'b1;
    hold_ticket = 0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset configuration: lowest and highest symbols of each width (two bytes: lowest only), then error cases
    add(8'h00, 1'b1); add(8'h7F, 1'b0);
    add(8'hC2, 1'b0); add(8'h80, 1'b0);
    add(8'hE0, 1'b0); add(8'hA0, 1'b0); add(8'h80, 1'b0);
    add(8'hEF, 1'b0); add(8'hBF, 1'b0); add(8'hBF, 1'b0);
    add(8'hF0, 1'b0); add(8'h90, 1'b0); add(8'h80, 1'b0); add(8'h80, 1'b0);
    add(8'hF7, 1'b0); add(8'hBF, 1'b0); add(8'hBF, 1'b0); add(8'hBF, 1'b0);
    add(8'hE2, 1'b0); add(8'h41, 1'b0); add(8'h41, 1'b0);
    add(8'hFF, 1'b1); add(8'h41, 1'b0);
    add(8'h80, 1'b1);
    add(8'hC3, 1'b1); add(8'h41, 1'b1);
    send_all();
    drain();

    // a long ASCII string sent back to back, ended by a stray continuation
    add(8'h41, 1'b1);
    for (i = 0; i < 200; i++) add(lead_byte(1), 1'b0);
    add(8'h90, 1'b0);
    add(8'h41, 1'b0);
    send_all();
    drain();

    ph_on   = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    ph_size = '{3'd1, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd7, 3'd6, 3'd2, 3'd3};
    ph_skip = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    fast_io = 1'b0;
    for (i = 0; i < 12; i++) begin
      set_reg(u8svd_pkg::REG_FIXED_ON, {2'b00, ph_on[i]});
      set_reg(u8svd_pkg::REG_FIXED_SIZE, ph_size[i]);
      set_reg(u8svd_pkg::REG_SKIP_CHECK, {2'b00, ph_skip[i]});
      build_random(140, ph_on[i], ph_size[i]);
      if (i == 0 || i == 6) hold_ticket++;
      send_all();
      drain();
    end

    repeat (5) @(negedge clk);
    if (chk_errors == 0 && chk_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/u8svd_pkg.sv
rtl/utf8_stream_validate_decode.sv
tb/sv/utf8_svd_check.sv
tb/sv/utf8_stream_validate_decode_tb.sv
